@@ rtl/rpr_pkg.sv @@
// Shared constants and constant functions for the rotary pair rotator.
// Used by rpr_angle, rpr_cordic, rpr_rotate and rope_pair_rotator; depends on nothing.
package rpr_pkg;

    // Widths fixed by the interface.
    localparam int POS_W   = 13;
    localparam int PAIR_W  = 7;
    localparam int STEP_W  = 24;
    localparam int TRIG_W  = 16;
    localparam int TURN_W  = 32;

    // Exponent split into integer and Q.20 fraction.
    localparam int EXP_W   = PAIR_W + STEP_W;
    localparam int EFRAC_W = 20;
    localparam int EINT_W  = EXP_W - EFRAC_W;

    // Fractional power in Q1.30 and the angle in Q30 radians.
    localparam int POW_W   = 31;
    localparam int FAC_W   = 30;
    localparam int RAD_W   = 43;
    localparam int RAD_LO_W = 22;
    localparam int RAD_HI_W = RAD_W - RAD_LO_W;

    // CORDIC datapath width, Q30 with headroom.
    localparam int CW      = 34;

    localparam logic [STEP_W-1:0] FREQ_STEP_RESET = 24'd217706;
    localparam logic [29:0]       TURN_PER_RAD    = 30'd683565276;
    localparam logic [CW-1:0]     CORDIC_GAIN     = 34'd652032874;
    localparam logic [TURN_W-1:0] QUARTER_TURN    = 32'h4000_0000;
    localparam logic [TURN_W-1:0] THREE_QUARTER   = 32'hC000_0000;
    localparam logic [TURN_W-1:0] HALF_TURN       = 32'h8000_0000;

    // Pipeline depth of the angle front end.
    localparam int ANGLE_LAT = EFRAC_W + 5;

    // Arc tangents in units of 2^-32 turn.
    localparam logic [29:0] ATAN_TURNS [24] = '{
        30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
        30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
        30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
        30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
        30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051
    };

    // Floor integer square root, evaluated at elaboration only.
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (b > v) begin
                b = b >> 2;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 64'd0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Factor 2^(-2^-(j+1)) in Q1.30 for fraction bit 19-j.
    function automatic logic [FAC_W-1:0] pow_factor(input int j);
        logic [63:0] r;
        r = isqrt64(64'd1 << 59);
        for (int i = 0; i < j; i++) begin
            r = isqrt64(r << 30);
        end
        return r[FAC_W-1:0];
    endfunction

endpackage

@@ rtl/rpr_angle.sv @@
// Angle front end: exponent, fractional power of two, scaled angle in turns.
// Depends on rpr_pkg.
module rpr_angle (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [rpr_pkg::POS_W-1:0]    position,
    input  logic [rpr_pkg::PAIR_W-1:0]   pair_index,
    input  logic [rpr_pkg::STEP_W-1:0]   freq_step,
    output logic                         out_valid,
    output logic [rpr_pkg::TURN_W-1:0]   turn
);
    import rpr_pkg::*;

    localparam int NP = EFRAC_W;

    logic [ANGLE_LAT-1:0]  v_reg;
    logic [POS_W-1:0]      pos_reg [NP+1];
    logic [EINT_W-1:0]     ei_reg  [NP+1];
    logic [EFRAC_W-1:0]    ef_reg  [NP+1];
    logic [POW_W-1:0]      f_reg   [NP+1];
    logic [EXP_W-1:0]      e_next;
    logic [RAD_W-1:0]      rad_pre_reg;
    logic [EINT_W-1:0]     ei_rad_reg;
    logic [RAD_W-1:0]      rad_reg;
    logic [RAD_HI_W+29:0]  ahi_reg;
    logic [RAD_LO_W-1:0]   rlo_reg;
    logic [72:0]           turn_sum;
    logic [TURN_W-1:0]     turn_reg;

    // Valid bits move with the data whenever the pipeline advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[ANGLE_LAT-2:0], in_valid};
        end
    end

    // Exponent product.
    assign e_next = EXP_W'(pair_index * freq_step);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_reg[0] <= position;
            ei_reg[0]  <= e_next[EXP_W-1:EFRAC_W];
            ef_reg[0]  <= e_next[EFRAC_W-1:0];
            f_reg[0]   <= POW_W'(64'd1 << 30);
        end
    end

    // One conditional rounded multiply per fraction bit, top bit first.
    for (genvar j = 1; j <= NP; j++)
    begin : g_pow
        localparam logic [FAC_W-1:0] FACTOR = pow_factor(j - 1);
        logic [POW_W+FAC_W-1:0] prod;
        assign prod = (POW_W+FAC_W)'(f_reg[j-1] * FACTOR) + (POW_W+FAC_W)'(64'd1 << 29);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pos_reg[j] <= pos_reg[j-1];
                ei_reg[j]  <= ei_reg[j-1];
                ef_reg[j]  <= ef_reg[j-1];
                f_reg[j]   <= ef_reg[j-1][NP-j] ? prod[POW_W+FAC_W-1:30] : f_reg[j-1];
            end
        end
    end

    // Angle, integer shift, and conversion to turns over two multiplies.
    assign turn_sum = {ahi_reg, 22'd0} + 73'(rlo_reg * TURN_PER_RAD);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_pre_reg <= RAD_W'(pos_reg[NP] * f_reg[NP]);
            ei_rad_reg  <= ei_reg[NP];
            rad_reg     <= rad_pre_reg >> ei_rad_reg;
            ahi_reg     <= (RAD_HI_W+30)'(rad_reg[RAD_W-1:RAD_LO_W] * TURN_PER_RAD);
            rlo_reg     <= rad_reg[RAD_LO_W-1:0];
            turn_reg    <= turn_sum[61:30];
        end
    end

    assign out_valid = v_reg[ANGLE_LAT-1];
    assign turn      = turn_reg;

endmodule

@@ rtl/rpr_cordic.sv @@
// Pipelined CORDIC giving cosine and sine in Q1.14 from an angle in turns.
// Depends on rpr_pkg.
module rpr_cordic #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [rpr_pkg::TURN_W-1:0]          turn,
    output logic                                out_valid,
    output logic signed [rpr_pkg::TRIG_W-1:0]   cos_value,
    output logic signed [rpr_pkg::TRIG_W-1:0]   sin_value
);
    import rpr_pkg::*;

    localparam int LAT = CORDIC_STAGES + 2;

    logic [LAT-1:0]        v_reg;
    logic signed [CW-1:0]  x_reg [CORDIC_STAGES+1];
    logic signed [CW-1:0]  y_reg [CORDIC_STAGES+1];
    logic signed [CW-1:0]  z_reg [CORDIC_STAGES+1];
    logic                  flip_reg [CORDIC_STAGES+1];
    logic                  flip_in;
    logic [TURN_W-1:0]     turn_adj;
    logic signed [CW-1:0]  xr;
    logic signed [CW-1:0]  yr;
    logic signed [17:0]    xc;
    logic signed [17:0]    yc;
    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[LAT-2:0], in_valid};
        end
    end

    // Fold the angle into the right half plane by a half turn.
    assign flip_in  = (turn > QUARTER_TURN) && (turn < THREE_QUARTER);
    assign turn_adj = flip_in ? turn + HALF_TURN : turn;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= {{(CW-TURN_W){turn_adj[TURN_W-1]}}, turn_adj};
            flip_reg[0] <= flip_in;
        end
    end

    // Rotation stages.
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        localparam logic signed [CW-1:0] ATAN = {{(CW-30){1'b0}}, ATAN_TURNS[i]};
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                flip_reg[i+1] <= flip_reg[i];
                if (!z_reg[i][CW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - ATAN;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + ATAN;
                end
            end
        end
    end

    // Round to Q1.14, clamp to one, and undo the half turn.
    assign xr = x_reg[CORDIC_STAGES] + CW'(32768);
    assign yr = y_reg[CORDIC_STAGES] + CW'(32768);

    always_comb
    begin
        xc = xr[CW-1:16];
        yc = yr[CW-1:16];
        if (xc > 18'sd16384)  xc = 18'sd16384;
        if (xc < -18'sd16384) xc = -18'sd16384;
        if (yc > 18'sd16384)  yc = 18'sd16384;
        if (yc < -18'sd16384) yc = -18'sd16384;
        if (flip_reg[CORDIC_STAGES])
        begin
            xc = -xc;
            yc = -yc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= xc[TRIG_W-1:0];
            sin_reg <= yc[TRIG_W-1:0];
        end
    end

    assign out_valid = v_reg[LAT-1];
    assign cos_value = cos_reg;
    assign sin_value = sin_reg;

endmodule

@@ rtl/rpr_rotate.sv @@
// Rotation of the query and key pairs with rounding and saturation.
// Depends on rpr_pkg.
module rpr_rotate #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [rpr_pkg::TRIG_W-1:0]   cos_in,
    input  logic signed [rpr_pkg::TRIG_W-1:0]   sin_in,
    input  logic signed [SAMPLE_BITS-1:0]       query_low,
    input  logic signed [SAMPLE_BITS-1:0]       query_high,
    input  logic signed [SAMPLE_BITS-1:0]       key_low,
    input  logic signed [SAMPLE_BITS-1:0]       key_high,
    output logic                                out_valid,
    output logic signed [SAMPLE_BITS-1:0]       query_low_out,
    output logic signed [SAMPLE_BITS-1:0]       query_high_out,
    output logic signed [SAMPLE_BITS-1:0]       key_low_out,
    output logic signed [SAMPLE_BITS-1:0]       key_high_out,
    output logic signed [rpr_pkg::TRIG_W-1:0]   cos_value,
    output logic signed [rpr_pkg::TRIG_W-1:0]   sin_value
);
    import rpr_pkg::*;

    localparam int PW = SAMPLE_BITS + TRIG_W;
    localparam int SW = PW + 1;

    // Signed saturation bounds at the sum width.
    localparam logic signed [SW-1:0] SAT_MAX =
        $signed(SW'({1'b0, {(SAMPLE_BITS-1){1'b1}}}));
    localparam logic signed [SW-1:0] SAT_MIN = -SAT_MAX - SW'(1);

    logic [1:0]              v_reg;
    logic signed [PW-1:0]    p_reg [8];
    logic signed [TRIG_W-1:0] c_reg;
    logic signed [TRIG_W-1:0] s_reg;
    logic signed [SAMPLE_BITS-1:0] r_reg [4];
    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sin_reg;
    logic signed [SW-1:0]    sums [4];
    logic signed [SAMPLE_BITS-1:0] sats [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[0], in_valid};
        end
    end

    // All eight products in parallel.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= PW'(query_low * cos_in);
            p_reg[1] <= PW'(query_high * sin_in);
            p_reg[2] <= PW'(query_high * cos_in);
            p_reg[3] <= PW'(query_low * sin_in);
            p_reg[4] <= PW'(key_low * cos_in);
            p_reg[5] <= PW'(key_high * sin_in);
            p_reg[6] <= PW'(key_high * cos_in);
            p_reg[7] <= PW'(key_low * sin_in);
            c_reg    <= cos_in;
            s_reg    <= sin_in;
        end
    end

    // Combine, round half up at Q14, then saturate.
    always_comb
    begin
        sums[0] = SW'(p_reg[0]) - SW'(p_reg[1]);
        sums[1] = SW'(p_reg[2]) + SW'(p_reg[3]);
        sums[2] = SW'(p_reg[4]) - SW'(p_reg[5]);
        sums[3] = SW'(p_reg[6]) + SW'(p_reg[7]);
        for (int k = 0; k < 4; k++)
        begin
            sums[k] = (sums[k] + SW'(8192)) >>> 14;
            if (sums[k] > SAT_MAX)
                sats[k] = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            else if (sums[k] < SAT_MIN)
                sats[k] = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            else
                sats[k] = sums[k][SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                r_reg[k] <= sats[k];
            end
            cos_reg <= c_reg;
            sin_reg <= s_reg;
        end
    end

    assign out_valid      = v_reg[1];
    assign query_low_out  = r_reg[0];
    assign query_high_out = r_reg[1];
    assign key_low_out    = r_reg[2];
    assign key_high_out   = r_reg[3];
    assign cos_value      = cos_reg;
    assign sin_value      = sin_reg;

endmodule

@@ rtl/rope_pair_rotator.sv @@
// Rotary position embedding for one query pair and one key pair per word.
// Throughput: one word per cycle; the whole pipeline holds while the output
// word waits, and nothing is lost or repeated.
// Reset clears all valid bits; freq_step returns to 217706.
// Depends on rpr_pkg, rpr_angle, rpr_cordic and rpr_rotate.
module rope_pair_rotator #(
    parameter int SAMPLE_BITS   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [rpr_pkg::POS_W-1:0]           position,
    input  logic [rpr_pkg::PAIR_W-1:0]          pair_index,
    input  logic signed [SAMPLE_BITS-1:0]       query_low,
    input  logic signed [SAMPLE_BITS-1:0]       query_high,
    input  logic signed [SAMPLE_BITS-1:0]       key_low,
    input  logic signed [SAMPLE_BITS-1:0]       key_high,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [SAMPLE_BITS-1:0]       query_low_out,
    output logic signed [SAMPLE_BITS-1:0]       query_high_out,
    output logic signed [SAMPLE_BITS-1:0]       key_low_out,
    output logic signed [SAMPLE_BITS-1:0]       key_high_out,
    output logic signed [rpr_pkg::TRIG_W-1:0]   cos_value,
    output logic signed [rpr_pkg::TRIG_W-1:0]   sin_value,
    input  logic                                cfg_wr_en,
    input  logic [rpr_pkg::STEP_W-1:0]          cfg_wr_data
);
    import rpr_pkg::*;

    localparam int DLY = ANGLE_LAT + CORDIC_STAGES + 2;
    localparam int SB  = SAMPLE_BITS;

    logic [STEP_W-1:0]       freq_step_reg;
    logic                    en;
    logic                    ang_valid;
    logic [TURN_W-1:0]       ang_turn;
    logic                    trig_valid;
    logic signed [TRIG_W-1:0] trig_cos;
    logic signed [TRIG_W-1:0] trig_sin;
    logic [4*SB-1:0]         smp_reg [DLY];

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_step_reg <= FREQ_STEP_RESET;
        end
        else if (cfg_wr_en)
        begin
            freq_step_reg <= cfg_wr_data;
        end
    end

    // The pipeline advances unless a finished word is held at the output.
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // Samples wait alongside the angle and CORDIC stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            smp_reg[0] <= {query_low, query_high, key_low, key_high};
            for (int i = 1; i < DLY; i++)
            begin
                smp_reg[i] <= smp_reg[i-1];
            end
        end
    end

    rpr_angle u_angle (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (in_valid),
        .position   (position),
        .pair_index (pair_index),
        .freq_step  (freq_step_reg),
        .out_valid  (ang_valid),
        .turn       (ang_turn)
    );

    rpr_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (ang_valid),
        .turn       (ang_turn),
        .out_valid  (trig_valid),
        .cos_value  (trig_cos),
        .sin_value  (trig_sin)
    );

    rpr_rotate #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_rotate (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (trig_valid),
        .cos_in         (trig_cos),
        .sin_in         (trig_sin),
        .query_low      (smp_reg[DLY-1][4*SB-1:3*SB]),
        .query_high     (smp_reg[DLY-1][3*SB-1:2*SB]),
        .key_low        (smp_reg[DLY-1][2*SB-1:SB]),
        .key_high       (smp_reg[DLY-1][SB-1:0]),
        .out_valid      (out_valid),
        .query_low_out  (query_low_out),
        .query_high_out (query_high_out),
        .key_low_out    (key_low_out),
        .key_high_out   (key_high_out),
        .cos_value      (cos_value),
        .sin_value      (sin_value)
    );

endmodule

@@ test/tb.sv @@
// Self-checking testbench for rope_pair_rotator: drives position, pair and sample words,
// predicts rotated pairs, cosine and sine, and compares each output word in order.
// Depends on rpr_pkg and rope_pair_rotator.
module tb;

    import rpr_pkg::*;

    typedef struct {
        logic signed [15:0] q_lo;
        logic signed [15:0] q_hi;
        logic signed [15:0] k_lo;
        logic signed [15:0] k_hi;
        logic signed [15:0] cos_v;
        logic signed [15:0] sin_v;
    } rot_word_t;

    localparam int LATENCY = 16 + 29;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [POS_W-1:0] position = '0;
    logic [PAIR_W-1:0] pair_index = '0;
    logic signed [15:0] query_low = '0;
    logic signed [15:0] query_high = '0;
    logic signed [15:0] key_low = '0;
    logic signed [15:0] key_high = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [15:0] query_low_out;
    logic signed [15:0] query_high_out;
    logic signed [15:0] key_low_out;
    logic signed [15:0] key_high_out;
    logic signed [15:0] cos_value;
    logic signed [15:0] sin_value;
    logic cfg_wr_en = 1'b0;
    logic [STEP_W-1:0] cfg_wr_data = '0;

    rot_word_t rotated_q[$];
    logic [STEP_W-1:0] step_model = FREQ_STEP_RESET;
    longint unsigned frac_factor [20];
    longint signed arc_turn [16];
    int fail_count = 0;
    int burst_left = 4;
    bit no_gaps = 1'b0;
    int hold_req = 0;
    int hold_left = 0;
    int stall_pct = 30;
    int pattern_cnt = 0;

    rope_pair_rotator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .position(position), .pair_index(pair_index),
        .query_low(query_low), .query_high(query_high),
        .key_low(key_low), .key_high(key_high),
        .out_valid(out_valid), .out_ready(out_ready),
        .query_low_out(query_low_out), .query_high_out(query_high_out),
        .key_low_out(key_low_out), .key_high_out(key_high_out),
        .cos_value(cos_value), .sin_value(sin_value),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always #5 clk = ~clk;

    // Floor square root of a 64-bit value.
    function automatic longint unsigned sqrt_floor(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned r;
        longint unsigned b;
        v = v_in;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Round half up by a right shift, then clamp.
    function automatic longint signed round_clamp(input longint signed v, input int s,
                                                  input longint signed lo,
                                                  input longint signed hi);
        longint signed r;
        r = (v + (longint'(1) <<< (s - 1))) >>> s;
        return r < lo ? lo : (r > hi ? hi : r);
    endfunction

    // Expected output word for one input word under the current step.
    function automatic rot_word_t rotate_pair(input logic [POS_W-1:0] pos,
                                              input logic [PAIR_W-1:0] pair,
                                              input logic signed [15:0] qlo,
                                              input logic signed [15:0] qhi,
                                              input logic signed [15:0] klo,
                                              input logic signed [15:0] khi);
        longint unsigned expo;
        longint unsigned eint;
        longint unsigned pw;
        longint unsigned rad;
        longint unsigned a_hi;
        longint unsigned b_lo;
        logic [31:0] turn;
        bit flip;
        longint signed x;
        longint signed y;
        longint signed z;
        longint signed xs;
        longint signed ys;
        longint signed c;
        longint signed s;
        rot_word_t w;
        expo = longint'(pair) * longint'(step_model);
        eint = expo >> 20;
        pw = 64'd1 << 30;
        for (int k = 19; k >= 0; k--)
            if (expo[k])
                pw = (pw * frac_factor[k] + (64'd1 << 29)) >> 30;
        rad = longint'(pos) * pw;
        rad = (eint >= 63) ? 0 : (rad >> eint);
        a_hi = (rad >> 22) * 64'd683565276;
        b_lo = (rad & 64'h3FFFFF) * 64'd683565276;
        turn = 32'((a_hi >> 8) + ((((a_hi & 255) << 22) + b_lo) >> 30));
        flip = 1'b0;
        // Fold the left half plane onto the right one; the flip negates the results.
        if (turn > 32'h4000_0000 && turn < 32'hC000_0000)
        begin
            turn = turn + 32'h8000_0000;
            flip = 1'b1;
        end
        z = longint'($signed(turn));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - arc_turn[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + arc_turn[i];
            end
        end
        c = round_clamp(x, 16, -16384, 16384);
        s = round_clamp(y, 16, -16384, 16384);
        if (flip)
        begin
            c = -c;
            s = -s;
        end
        w.q_lo = 16'(round_clamp(qlo * c - qhi * s, 14, -32768, 32767));
        w.q_hi = 16'(round_clamp(qhi * c + qlo * s, 14, -32768, 32767));
        w.k_lo = 16'(round_clamp(klo * c - khi * s, 14, -32768, 32767));
        w.k_hi = 16'(round_clamp(khi * c + klo * s, 14, -32768, 32767));
        w.cos_v = 16'(c);
        w.sin_v = 16'(s);
        return w;
    endfunction

    // Offer one word, hold it until accepted, then record its expected result.
    task automatic send_word(input logic [POS_W-1:0] pos, input logic [PAIR_W-1:0] pair,
                             input logic [15:0] qlo, input logic [15:0] qhi,
                             input logic [15:0] klo, input logic [15:0] khi);
        in_valid <= 1'b1;
        position <= pos;
        pair_index <= pair;
        query_low <= qlo;
        query_high <= qhi;
        key_low <= klo;
        key_high <= khi;
        do
            @(posedge clk);
        while (!in_ready);
        rotated_q.push_back(rotate_pair(pos, pair, qlo, qhi, klo, khi));
        burst_left--;
        if (!no_gaps && burst_left <= 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
    endtask

    // A random sample, with extremes mixed in.
    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random();
        send_word(13'($urandom), 7'($urandom), rand_sample(), rand_sample(),
                  rand_sample(), rand_sample());
    endtask

    // Lower valid and wait until every expected word has come out.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (rotated_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_step(input logic [STEP_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        step_model = v;
    endtask

    // Field extremes, saturation corners and the zero-angle case.
    task automatic test_directed();
        send_word(13'd0, 7'd0, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        send_word(13'd8191, 7'd0, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
        send_word(13'd8191, 7'd127, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
        send_word(13'd1, 7'd0, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
        send_word(13'd2, 7'd0, 16'h0000, 16'hFFFF, 16'h0001, 16'h0000);
        send_word(13'd3, 7'd0, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000);
        send_word(13'd5, 7'd1, 16'h1234, 16'hEDCB, 16'h5555, 16'hAAAA);
        send_word(13'd4096, 7'd64, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_word(13'd6283, 7'd0, 16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF);
        drain();
        // Huge exponent: the angle collapses to zero for the first two words.
        write_step(24'hFFFFFF);
        send_word(13'd8191, 7'd127, 16'h7FFF, 16'h8000, 16'h1111, 16'hEEEE);
        send_word(13'd8191, 7'd4, 16'h8000, 16'h7FFF, 16'h2222, 16'hDDDD);
        send_word(13'd100, 7'd1, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
        drain();
        write_step(24'd0);
        send_word(13'd8191, 7'd127, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
        send_word(13'd4321, 7'd99, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
        drain();
        write_step(FREQ_STEP_RESET);
    endtask

    // Random words under several step settings, extremes included.
    task automatic test_step_sweep();
        logic [STEP_W-1:0] steps [6];
        steps = '{24'd0, 24'hFFFFFF, 24'd1, 24'h100000, 24'($urandom), FREQ_STEP_RESET};
        foreach (steps[i])
        begin
            drain();
            write_step(steps[i]);
            repeat (90) send_random();
        end
    endtask

    task automatic test_random_stream();
        repeat (700) send_random();
    endtask

    // The receiver holds off for a long stretch while words keep coming.
    task automatic test_backpressure();
        drain();
        no_gaps = 1'b1;
        hold_req = 400;
        repeat (120) send_random();
        no_gaps = 1'b0;
        drain();
    endtask

    task automatic test_quiet_restart();
        repeat (40) send_random();
        drain();
        repeat (40) send_random();
    endtask

    // Receiver: random stall pattern that changes mode, plus requested hold-offs.
    always @(posedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        pattern_cnt++;
        if (pattern_cnt % 150 == 0)
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Compare each accepted output word with the oldest expectation.
    always @(posedge clk)
    begin
        rot_word_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (rotated_q.size() == 0)
            begin
                $error("output word with no expectation");
                fail_count++;
            end
            else
            begin
                w = rotated_q.pop_front();
                if (query_low_out !== w.q_lo)
                begin
                    $error("query_low_out exp %0d got %0d", w.q_lo, query_low_out);
                    fail_count++;
                end
                if (query_high_out !== w.q_hi)
                begin
                    $error("query_high_out exp %0d got %0d", w.q_hi, query_high_out);
                    fail_count++;
                end
                if (key_low_out !== w.k_lo)
                begin
                    $error("key_low_out exp %0d got %0d", w.k_lo, key_low_out);
                    fail_count++;
                end
                if (key_high_out !== w.k_hi)
                begin
                    $error("key_high_out exp %0d got %0d", w.k_hi, key_high_out);
                    fail_count++;
                end
                if (cos_value !== w.cos_v)
                begin
                    $error("cos_value exp %0d got %0d", w.cos_v, cos_value);
                    fail_count++;
                end
                if (sin_value !== w.sin_v)
                begin
                    $error("sin_value exp %0d got %0d", w.sin_v, sin_value);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        longint unsigned r;
        longint signed atan_src [16];
        atan_src = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                     64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                     64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                     64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};
        arc_turn = atan_src;
        // Factors 2^(-1/2), 2^(-1/4), ... for fraction bits 19 down to 0.
        r = sqrt_floor(64'd1 << 59);
        for (int k = 19; k >= 0; k--)
        begin
            frac_factor[k] = r;
            r = sqrt_floor(r << 30);
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_step_sweep();
        test_random_stream();
        test_backpressure();
        test_quiet_restart();
        drain();
        if (rotated_q.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
